@@ hdl/wpsg_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wpsg_pkg
// Types, constants and helpers shared by the wavetable sound generator.
// ---------------------------------------------------------------------------
package wpsg_pkg;

    localparam int SUBSAMPLES_DEF = 4;
    localparam int WAVE_LEN       = 32;
    localparam int RAM_WIDTH      = 8;    // two nibbles per entry
    localparam int RAM_DEPTH      = 64;   // 4 channels x 16 bytes
    localparam int RAM_AW         = $clog2(RAM_DEPTH);

    localparam logic [7:0]  WAVE_FILL   = 8'h88;
    localparam logic [7:0]  GAIN_RESET  = 8'd40;
    localparam logic [6:0]  MUTE_RESET  = 7'h7F;
    localparam logic [15:0] LFSR_RESET  = 16'd3;
    localparam logic [3:0]  DEG_RESET   = 4'd2;
    localparam logic [3:0]  DEG_MAX     = 4'd15;

    // register map of write items
    localparam logic [6:0] ADDR_FREQ  = 7'd64;
    localparam logic [6:0] ADDR_VOL   = 7'd68;
    localparam logic [6:0] ADDR_CTRL  = 7'd72;
    localparam logic [6:0] ADDR_SSTEP = 7'd73;
    localparam logic [6:0] ADDR_STIME = 7'd74;
    localparam logic [6:0] ADDR_NOISE = 7'd75;

    // op codes and config indexes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam logic CFG_MUTE = 1'b0;
    localparam logic CFG_GAIN = 1'b1;

    typedef struct packed {
        logic       op;
        logic [6:0] reg_addr;
        logic [10:0] wdata;
        logic [7:0] voice_byte;
        logic [7:0] hyper_byte;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_CHAN,
        ST_RELOAD,
        ST_READ,
        ST_ACC,
        ST_GAIN,
        ST_OUT
    } t_state;

    function automatic logic [15:0] lfsr_taps(input logic [2:0] idx);
        logic [15:0] t;
        case (idx)
            3'd0:    t = 16'h1D;
            3'd1:    t = 16'h11;
            3'd2:    t = 16'h09;
            3'd3:    t = 16'h05;
            3'd4:    t = 16'h53;
            3'd5:    t = 16'h1B;
            3'd6:    t = 16'h33;
            3'd7:    t = 16'h03;
            default: t = 16'h03;
        endcase
        return t;
    endfunction

    // One noise step; trims the register when the degree changes.
    function automatic logic [15:0] lfsr_next(input logic [15:0] cur,
                                              input logic [3:0]  cur_deg,
                                              input logic [3:0]  deg);
        logic [15:0] top;
        logic [15:0] l;
        logic        par;
        top = 16'd1 << deg;
        l   = cur;
        if (cur_deg != deg) begin
            l = l & (top - 16'd1);
            if (l == 16'd0) begin
                l = top - 16'd1;
            end
        end
        par = ^(l & lfsr_taps(3'(deg - 4'd8)));
        l   = par ? (l | top) : (l & ~top);
        return l >> 1;
    endfunction

endpackage
`default_nettype wire

@@ hdl/wpsg_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wpsg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wpsg_ram #(
    parameter int WIDTH = wpsg_pkg::RAM_WIDTH,
    parameter int DEPTH = wpsg_pkg::RAM_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hdl/wavetable_psg_mixer_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wavetable_psg_mixer_core
// Four-channel wavetable sound generator with LFSR noise and voice mixing.
// ---------------------------------------------------------------------------
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  item in  | i_item (t_in)                  | start & !busy
//  result   | o_result (t_out)               | o_res_strobe, one cycle
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata| i_cfg_we, no wait
//
// A write item is taken in the idle state. A tick item runs a sweep step,
// then per sample and per enabled channel a channel step, phase reloads, a
// RAM read and an accumulate step (a skipped channel has only the channel
// step), then gain and saturation. Reloads per channel are at most 65
// (64 once the phase has been reloaded). After reset the wave RAM is filled
// with the mid level, all 64 entries, while busy is high. Results cannot be
// stalled: each sample shows for one cycle on o_res_strobe.
// ---------------------------------------------------------------------------
module wavetable_psg_mixer_core #(
    parameter int SUBSAMPLES = wpsg_pkg::SUBSAMPLES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire wpsg_pkg::t_in  i_item,
    output wpsg_pkg::t_out      o_result,
    output logic                o_res_strobe,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_idx,
    input  wire logic [7:0]     i_cfg_wdata
);
    localparam int KW = (SUBSAMPLES > 1) ? $clog2(SUBSAMPLES) : 1;
    localparam int AW = wpsg_pkg::RAM_AW;

    wpsg_pkg::t_state r_state, n_state;

    // sequencer
    logic [1:0]         r_ch, n_ch;
    logic [KW-1:0]      r_k, n_k;
    logic [AW-1:0]      r_clr, n_clr;
    logic signed [11:0] r_mix, n_mix;
    logic signed [20:0] r_prod, n_prod;
    logic [7:0]         r_voice, n_voice;
    logic [7:0]         r_hyper, n_hyper;

    // channel state
    logic signed [12:0] r_phase [4];
    logic signed [12:0] n_phase [4];
    logic [4:0]         r_pos [4];
    logic [4:0]         n_pos [4];
    logic [10:0]        r_freq [4];
    logic [10:0]        n_freq [4];
    logic [3:0]         r_vl [4];
    logic [3:0]         n_vl [4];
    logic [3:0]         r_vr [4];
    logic [3:0]         n_vr [4];
    logic [6:0]         r_ctrl, n_ctrl;
    logic [10:0]        r_sstep, n_sstep;
    logic [7:0]         r_stime, n_stime;
    logic signed [9:0]  r_scount, n_scount;
    logic [2:0]         r_npat, n_npat;
    logic               r_nbit, n_nbit;
    logic [15:0]        r_lfsr, n_lfsr;
    logic [3:0]         r_ldeg, n_ldeg;
    logic [6:0]         r_mute, n_mute;
    logic [7:0]         r_gain, n_gain;

    // output register
    wpsg_pkg::t_out     r_out, n_out;
    logic               r_strobe, n_strobe;

    // wave RAM port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    logic               accept;
    logic               voice_on;
    logic               noise_path;
    logic               skip;
    logic [11:0]        period;
    logic [3:0]         nib;
    logic signed [4:0]  val;
    logic signed [5:0]  vsum;
    logic signed [10:0] base;
    logic [3:0]         ndeg;
    logic [15:0]        lfsr_n;
    logic               last_ch;
    logic               last_k;

    wpsg_ram #(
        .WIDTH (wpsg_pkg::RAM_WIDTH),
        .DEPTH (wpsg_pkg::RAM_DEPTH)
    ) u_wave (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy         = (r_state != wpsg_pkg::ST_IDLE);
    assign accept       = start && !busy;
    assign o_result     = r_out;
    assign o_res_strobe = r_strobe;

    // per-channel gating
    assign voice_on   = r_ctrl[4] && r_mute[4];
    assign noise_path = (r_ch == 2'd3) && r_ctrl[6] && r_mute[6];
    assign skip       = !r_ctrl[r_ch]
                     || ((r_ch == 2'd1) && voice_on)
                     || ((r_ch == 2'd2) && r_ctrl[5] && !r_mute[5])
                     || (!noise_path && !r_mute[r_ch]);
    assign period     = 12'd2048 - {1'b0, r_freq[r_ch]};
    assign last_ch    = (r_ch == 2'd3);
    assign last_k     = (r_k == KW'(SUBSAMPLES - 1));

    assign ram_raddr  = {r_ch, r_pos[r_ch][4:1]};
    assign nib        = r_pos[r_ch][0] ? ram_rdata[7:4] : ram_rdata[3:0];
    assign val        = noise_path ? (r_nbit ? 5'sd7 : -5'sd8)
                                   : $signed({1'b0, nib}) - 5'sd8;
    assign vsum       = $signed({2'b00, r_vl[r_ch]}) + $signed({2'b00, r_vr[r_ch]});

    // voice bytes weighted by two, offset-binary to signed
    assign base = (voice_on ? ($signed({3'b000, r_voice}) - 11'sd128) <<< 1 : 11'sd0)
                + (($signed({3'b000, r_hyper}) - 11'sd128) <<< 1);

    assign ndeg   = wpsg_pkg::DEG_MAX - {1'b0, r_npat};
    assign lfsr_n = wpsg_pkg::lfsr_next(r_lfsr, r_ldeg, ndeg);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wpsg_pkg::ST_CLEAR: begin
                if (r_clr == AW'(wpsg_pkg::RAM_DEPTH - 1)) n_state = wpsg_pkg::ST_IDLE;
            end
            wpsg_pkg::ST_IDLE: begin
                if (accept && i_item.op == wpsg_pkg::OP_TICK) n_state = wpsg_pkg::ST_SWEEP;
            end
            wpsg_pkg::ST_SWEEP: begin
                n_state = wpsg_pkg::ST_CHAN;
            end
            wpsg_pkg::ST_CHAN: begin
                if (!skip)        n_state = wpsg_pkg::ST_RELOAD;
                else if (last_ch) n_state = wpsg_pkg::ST_GAIN;
            end
            wpsg_pkg::ST_RELOAD: begin
                if (r_phase[r_ch] > 13'sd0) n_state = wpsg_pkg::ST_READ;
            end
            wpsg_pkg::ST_READ: begin
                n_state = wpsg_pkg::ST_ACC;
            end
            wpsg_pkg::ST_ACC: begin
                n_state = last_ch ? wpsg_pkg::ST_GAIN : wpsg_pkg::ST_CHAN;
            end
            wpsg_pkg::ST_GAIN: begin
                n_state = wpsg_pkg::ST_OUT;
            end
            wpsg_pkg::ST_OUT: begin
                n_state = last_k ? wpsg_pkg::ST_IDLE : wpsg_pkg::ST_CHAN;
            end
            default: n_state = wpsg_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_ch     = r_ch;
        n_k      = r_k;
        n_clr    = r_clr;
        n_mix    = r_mix;
        n_prod   = r_prod;
        n_voice  = r_voice;
        n_hyper  = r_hyper;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_freq   = r_freq;
        n_vl     = r_vl;
        n_vr     = r_vr;
        n_ctrl   = r_ctrl;
        n_sstep  = r_sstep;
        n_stime  = r_stime;
        n_scount = r_scount;
        n_npat   = r_npat;
        n_nbit   = r_nbit;
        n_lfsr   = r_lfsr;
        n_ldeg   = r_ldeg;
        n_mute   = r_mute;
        n_gain   = r_gain;
        n_out    = r_out;
        n_strobe = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = i_item.reg_addr[AW-1:0];
        ram_wdata = i_item.wdata[7:0];

        if (i_cfg_we) begin
            case (i_cfg_idx)
                wpsg_pkg::CFG_MUTE: n_mute = i_cfg_wdata[6:0];
                wpsg_pkg::CFG_GAIN: n_gain = i_cfg_wdata;
                default: ;
            endcase
        end

        case (r_state)
            wpsg_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = wpsg_pkg::WAVE_FILL;
                n_clr     = r_clr + AW'(1);
            end
            wpsg_pkg::ST_IDLE: begin
                if (accept) begin
                    n_voice = i_item.voice_byte;
                    n_hyper = i_item.hyper_byte;
                    if (i_item.op == wpsg_pkg::OP_WRITE) begin
                        if (i_item.reg_addr < wpsg_pkg::ADDR_FREQ) begin
                            ram_we = 1'b1;
                        end else if (i_item.reg_addr < wpsg_pkg::ADDR_VOL) begin
                            n_freq[i_item.reg_addr[1:0]] = i_item.wdata;
                        end else if (i_item.reg_addr < wpsg_pkg::ADDR_CTRL) begin
                            n_vl[i_item.reg_addr[1:0]] = i_item.wdata[7:4];
                            n_vr[i_item.reg_addr[1:0]] = i_item.wdata[3:0];
                        end else if (i_item.reg_addr == wpsg_pkg::ADDR_CTRL) begin
                            n_ctrl = i_item.wdata[6:0];
                        end else if (i_item.reg_addr == wpsg_pkg::ADDR_SSTEP) begin
                            n_sstep = {{3{i_item.wdata[7]}}, i_item.wdata[7:0]};
                        end else if (i_item.reg_addr == wpsg_pkg::ADDR_STIME) begin
                            n_stime = i_item.wdata[7:0];
                        end else if (i_item.reg_addr == wpsg_pkg::ADDR_NOISE) begin
                            n_npat = i_item.wdata[2:0];
                        end
                    end
                end
            end
            wpsg_pkg::ST_SWEEP: begin
                // channel 2 frequency sweep, once per tick
                if (r_sstep != 11'd0 && r_ctrl[5]) begin
                    if (r_scount < 10'sd0) begin
                        n_scount  = $signed({2'b00, r_stime}) - 10'sd1;
                        n_freq[2] = r_freq[2] + r_sstep;
                    end else begin
                        n_scount = r_scount - 10'sd1;
                    end
                end
                n_ch  = 2'd0;
                n_k   = '0;
                n_mix = 12'(base);
            end
            wpsg_pkg::ST_CHAN: begin
                if (!skip) begin
                    n_phase[r_ch] = r_phase[r_ch] - 13'sd64;
                end else if (!last_ch) begin
                    n_ch = r_ch + 2'd1;
                end
            end
            wpsg_pkg::ST_RELOAD: begin
                if (r_phase[r_ch] <= 13'sd0) begin
                    n_phase[r_ch] = r_phase[r_ch] + $signed({1'b0, period});
                    if (noise_path) begin
                        n_lfsr = lfsr_n;
                        n_ldeg = ndeg;
                        n_nbit = lfsr_n[0];
                    end else begin
                        n_pos[r_ch] = r_pos[r_ch] + 5'd1;
                    end
                end
            end
            wpsg_pkg::ST_READ: ;
            wpsg_pkg::ST_ACC: begin
                n_mix = r_mix + 12'(val) * 12'(vsum);
                if (!last_ch) n_ch = r_ch + 2'd1;
            end
            wpsg_pkg::ST_GAIN: begin
                n_prod = r_mix * $signed({1'b0, r_gain});
            end
            wpsg_pkg::ST_OUT: begin
                if (r_prod > 21'sd32767)       n_out.sample = 16'sh7FFF;
                else if (r_prod < -21'sd32768) n_out.sample = 16'sh8000;
                else                           n_out.sample = r_prod[15:0];
                n_out.last = last_k;
                n_strobe   = 1'b1;
                n_ch       = 2'd0;
                n_k        = r_k + KW'(1);
                n_mix      = 12'(base);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wpsg_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_ch     <= '0;
            r_k      <= '0;
            r_strobe <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_phase[i] <= '0;
                r_pos[i]   <= '0;
                r_freq[i]  <= '0;
                r_vl[i]    <= '0;
                r_vr[i]    <= '0;
            end
            r_ctrl   <= '0;
            r_sstep  <= '0;
            r_stime  <= '0;
            r_scount <= '0;
            r_npat   <= '0;
            r_nbit   <= 1'b0;
            r_lfsr   <= wpsg_pkg::LFSR_RESET;
            r_ldeg   <= wpsg_pkg::DEG_RESET;
            r_mute   <= wpsg_pkg::MUTE_RESET;
            r_gain   <= wpsg_pkg::GAIN_RESET;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ch     <= n_ch;
            r_k      <= n_k;
            r_strobe <= n_strobe;
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_freq   <= n_freq;
            r_vl     <= n_vl;
            r_vr     <= n_vr;
            r_ctrl   <= n_ctrl;
            r_sstep  <= n_sstep;
            r_stime  <= n_stime;
            r_scount <= n_scount;
            r_npat   <= n_npat;
            r_nbit   <= n_nbit;
            r_lfsr   <= n_lfsr;
            r_ldeg   <= n_ldeg;
            r_mute   <= n_mute;
            r_gain   <= n_gain;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mix   <= n_mix;
        r_prod  <= n_prod;
        r_voice <= n_voice;
        r_hyper <= n_hyper;
        r_out   <= n_out;
    end

endmodule
`default_nettype wire
